### sv/rtos_message_queue_defines.svh
// assertion macros for the message queue top level
`ifndef RTOS_MESSAGE_QUEUE_DEFINES_SVH
`define RTOS_MESSAGE_QUEUE_DEFINES_SVH

// same-cycle implication, checked on the rising edge of clk outside reset
`define RMQ_ASSERT_SAME(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rtos_message_queue check failed");

// next-cycle implication, checked on the rising edge of clk outside reset
`define RMQ_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rtos_message_queue check failed");

`endif

### sv/rmq_pkg.sv
// types, codes and helpers shared by the message queue modules
`default_nettype none

package rmq_pkg;

    localparam int TASK_FIELD_W = 4;
    localparam logic [TASK_FIELD_W-1:0] TASK_BIT_TOP = 4'h8;
    localparam logic [TASK_FIELD_W-1:0] TASK_FIELD_MASK = 4'hF;

    localparam int FLAG_BROADCAST = 0;
    localparam int FLAG_FRONT = 1;
    localparam int FLAG_REMOVE = 2;

    typedef enum logic [1:0] {
        KIND_PEND   = 2'd0,
        KIND_POST   = 2'd1,
        KIND_ACCEPT = 2'd2,
        KIND_RESUME = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        STAT_OK      = 3'd0,
        STAT_FULL    = 3'd1,
        STAT_EMPTY   = 3'd2,
        STAT_TIMEOUT = 3'd3,
        STAT_WAITING = 3'd4
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } rmq_state_t;

    typedef struct packed {
        logic capture;
        logic commit;
    } rmq_cmd_t;

    // task 0 owns the top bit of the mask
    function automatic logic [TASK_FIELD_W-1:0] task_bit(input logic [1:0] t);
        return (TASK_BIT_TOP >> t) & TASK_FIELD_MASK;
    endfunction

endpackage

`default_nettype wire

### sv/rtos_message_queue.sv
// top level of the message queue engine: controller plus datapath
//
//  channel   handshake             payload
//  request   req_valid/req_stall   kind, task_req, message, opt_flags
//  result    rsp_valid/rsp_stall   status, message_out, woken_tasks, message_count
//
// each request is captured, with the ring head read, and then committed
// the single ring memory port sets this: read at capture, write at commit
// one request at a time; a new request is taken while a result waits to be taken
// a commit waits while the result register is full and stalled
// reset is asynchronous and active low; the ring itself is not cleared
`default_nettype none

`include "rtos_message_queue_defines.svh"

module rtos_message_queue
    import rmq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int TASK_COUNT  = 4,
    parameter int MSG_WIDTH   = 8
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              req_valid,
    output logic                                   req_stall,
    input  wire logic [1:0]                        kind,
    input  wire logic [1:0]                        task_req,
    input  wire logic [MSG_WIDTH-1:0]              message,
    input  wire logic [2:0]                        opt_flags,
    output logic                                   rsp_valid,
    input  wire logic                              rsp_stall,
    output logic [2:0]                             status,
    output logic [MSG_WIDTH-1:0]                   message_out,
    output logic [TASK_FIELD_W-1:0]                woken_tasks,
    output logic [$clog2(QUEUE_DEPTH + 1)-1:0]     message_count
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    // commands from the controller to the datapath
    rmq_cmd_t cmd;

    rmq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd)
    );

    rmq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TASK_COUNT  (TASK_COUNT),
        .MSG_WIDTH   (MSG_WIDTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .kind          (kind),
        .task_req      (task_req),
        .message       (message),
        .opt_flags     (opt_flags),
        .status        (status),
        .message_out   (message_out),
        .woken_tasks   (woken_tasks),
        .message_count (message_count)
    );

    // an accepted request keeps the block busy for its commit cycle
    `RMQ_ASSERT_NEXT(a_busy_after_req, req_valid && !req_stall, req_stall)

    // a new result only appears at the end of a busy cycle
    `RMQ_ASSERT_SAME(a_rsp_after_busy, $rose(rsp_valid), $past(req_stall))

    // the ring never reports more than it can hold
    `RMQ_ASSERT_SAME(a_count_bound, rsp_valid, message_count <= CNT_W'(QUEUE_DEPTH))

    // a handoff is a successful post, which returns no message
    `RMQ_ASSERT_SAME(a_handoff_ok, rsp_valid && (woken_tasks != '0), (status == STAT_OK) && (message_out == '0))

endmodule

`default_nettype wire

### sv/rmq_ctrl.sv
// controller state machine: request capture, commit and result handshake
`default_nettype none

module rmq_ctrl
    import rmq_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_stall,
    output logic          rsp_valid,
    input  wire logic     rsp_stall,
    output rmq_cmd_t      cmd
);

    rmq_state_t state_reg, state_next;
    logic       rsp_valid_reg, rsp_valid_next;
    logic       commit_ok;

    assign commit_ok = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (commit_ok)
                begin
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    always_comb
    begin
        req_stall      = (state_reg != S_IDLE);
        cmd.capture    = (state_reg == S_IDLE) && req_valid;
        cmd.commit     = (state_reg == S_EXEC) && commit_ok;
        rsp_valid_next = cmd.commit || (rsp_valid_reg && rsp_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;

endmodule

`default_nettype wire

### sv/rmq_datapath.sv
// datapath: ring memory, indexes, waiter mask, handoff slots, result register
`default_nettype none

module rmq_datapath
    import rmq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int TASK_COUNT  = 4,
    parameter int MSG_WIDTH   = 8,
    localparam int IDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1),
    localparam int SLOT_W = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire rmq_cmd_t                cmd,
    input  wire logic [1:0]              kind,
    input  wire logic [1:0]              task_req,
    input  wire logic [MSG_WIDTH-1:0]    message,
    input  wire logic [2:0]              opt_flags,
    output logic [2:0]                   status,
    output logic [MSG_WIDTH-1:0]         message_out,
    output logic [TASK_FIELD_W-1:0]      woken_tasks,
    output logic [CNT_W-1:0]             message_count
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);

    // captured request
    kind_t                  kind_reg;
    logic [1:0]             task_reg;
    logic [MSG_WIDTH-1:0]   msg_reg;
    logic [2:0]             flags_reg;

    // queue state
    logic [MSG_WIDTH-1:0]   ring_mem [QUEUE_DEPTH];
    logic [MSG_WIDTH-1:0]   rd_data_reg;
    logic [IDX_W-1:0]       head_reg, head_next;
    logic [IDX_W-1:0]       tail_reg, tail_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [TASK_FIELD_W-1:0] waiter_reg, waiter_next;
    logic [MSG_WIDTH-1:0]   slot_reg  [TASK_COUNT];
    logic [MSG_WIDTH-1:0]   slot_next [TASK_COUNT];

    // result
    status_t                status_reg, status_next;
    logic [MSG_WIDTH-1:0]   mout_reg, mout_next;
    logic [TASK_FIELD_W-1:0] woken_reg, woken_next;

    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;
    logic [IDX_W-1:0]       head_inc, head_dec, tail_inc;
    logic                   valid_task;
    logic                   ring_empty, ring_full;
    logic [TASK_FIELD_W-1:0] own_bit;
    logic [SLOT_W-1:0]      slot_idx;

    assign head_inc   = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
    assign head_dec   = (head_reg == '0) ? LAST_IDX : head_reg - 1'b1;
    assign tail_inc   = (tail_reg == LAST_IDX) ? '0 : tail_reg + 1'b1;
    assign valid_task = ({1'b0, task_reg} < 3'(TASK_COUNT));
    assign ring_empty = (count_reg == '0);
    assign ring_full  = (count_reg >= CNT_W'(QUEUE_DEPTH));
    assign own_bit    = task_bit(task_reg);
    assign slot_idx   = task_reg[SLOT_W-1:0];

    always_comb
    begin
        logic found;
        found       = 1'b0;
        status_next = STAT_OK;
        mout_next   = '0;
        woken_next  = '0;
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        waiter_next = waiter_reg;
        slot_next   = slot_reg;
        wr_en       = 1'b0;
        wr_addr     = tail_reg;
        unique case (kind_reg)
            KIND_PEND:
            begin
                if (!ring_empty)
                begin
                    mout_next  = rd_data_reg;
                    head_next  = head_inc;
                    count_next = count_reg - 1'b1;
                end
                else if (valid_task)
                begin
                    waiter_next = waiter_reg | own_bit;
                    status_next = STAT_WAITING;
                end
                else
                begin
                    status_next = STAT_EMPTY;
                end
            end
            KIND_POST:
            begin
                if (ring_full)
                begin
                    status_next = STAT_FULL;
                end
                else if (waiter_reg != '0)
                begin
                    // highest priority waiter first, or every waiter on broadcast
                    for (int t = 0; t < TASK_COUNT; t++)
                    begin
                        if (((waiter_reg & task_bit(2'(t))) != '0) &&
                            (!found || flags_reg[FLAG_BROADCAST]))
                        begin
                            woken_next   = woken_next | task_bit(2'(t));
                            waiter_next  = waiter_next & ~task_bit(2'(t));
                            slot_next[t] = msg_reg;
                            found        = 1'b1;
                        end
                    end
                end
                else if (msg_reg != '0)
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + 1'b1;
                    if (flags_reg[FLAG_FRONT])
                    begin
                        head_next = head_dec;
                        wr_addr   = head_dec;
                    end
                    else
                    begin
                        tail_next = tail_inc;
                        wr_addr   = tail_reg;
                    end
                end
            end
            KIND_ACCEPT:
            begin
                if (!ring_empty)
                begin
                    mout_next = rd_data_reg;
                    if (flags_reg[FLAG_REMOVE])
                    begin
                        head_next  = head_inc;
                        count_next = count_reg - 1'b1;
                    end
                end
                else
                begin
                    status_next = STAT_EMPTY;
                end
            end
            KIND_RESUME:
            begin
                if (!valid_task)
                begin
                    status_next = STAT_TIMEOUT;
                end
                else if (slot_reg[slot_idx] != '0)
                begin
                    mout_next           = slot_reg[slot_idx];
                    slot_next[slot_idx] = '0;
                end
                else
                begin
                    waiter_next = waiter_reg & ~own_bit;
                    status_next = STAT_TIMEOUT;
                end
            end
        endcase
    end

    // request capture, head read and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg    <= kind_t'(kind);
            task_reg    <= task_req;
            msg_reg     <= message;
            flags_reg   <= opt_flags;
            rd_data_reg <= ring_mem[head_reg];
        end
        if (cmd.commit)
        begin
            status_reg <= status_next;
            mout_reg   <= mout_next;
            woken_reg  <= woken_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit && wr_en)
        begin
            ring_mem[wr_addr] <= msg_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            tail_reg   <= '0;
            count_reg  <= '0;
            waiter_reg <= '0;
            for (int i = 0; i < TASK_COUNT; i++)
            begin
                slot_reg[i] <= '0;
            end
        end
        else if (cmd.commit)
        begin
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            count_reg  <= count_next;
            waiter_reg <= waiter_next;
            slot_reg   <= slot_next;
        end
    end

    assign status        = status_reg;
    assign message_out   = mout_reg;
    assign woken_tasks   = woken_reg;
    assign message_count = count_reg;

endmodule

`default_nettype wire

### tb/tb.sv
// self-checking testbench for the rtos message queue engine
`default_nettype none

module tb
    import rmq_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // the queue geometry this bench predicts for
    localparam int RING_DEPTH = 16;
    localparam int TASK_NUM   = 4;
    localparam int MSG_W      = 8;

    // each burst of random requests follows one of this set of traffic shapes
    typedef enum int {
        MIX_ANY,
        MIX_FILL,
        MIX_DRAIN,
        MIX_WAITERS
    } traffic_mix_t;

    // what one request should give back
    typedef struct packed {
        status_t          st;
        logic [MSG_W-1:0] msg;
        logic [3:0]       woken;
        logic [4:0]       count;
    } queue_result_t;

    logic             clk;
    logic             rst_n;
    logic             req_valid;
    logic             req_stall;
    logic [1:0]       kind;
    logic [1:0]       task_req;
    logic [MSG_W-1:0] message;
    logic [2:0]       opt_flags;
    logic             rsp_valid;
    logic             rsp_stall;
    logic [2:0]       status;
    logic [MSG_W-1:0] message_out;
    logic [3:0]       woken_tasks;
    logic [4:0]       message_count;

    // shadow copy of the queue state, advanced once per accepted request
    logic [MSG_W-1:0] ring_mem [RING_DEPTH];
    logic [3:0]       head_ptr;
    logic [3:0]       tail_ptr;
    logic [4:0]       held;
    logic [3:0]       wait_mask;
    logic [MSG_W-1:0] slot_msg [TASK_NUM];

    // results still owed by the block, oldest first
    queue_result_t    owed_results [$];

    int               failures;
    int               send_idle_pct;
    int               recv_stall_pct;

    rtos_message_queue #(
        .QUEUE_DEPTH (RING_DEPTH),
        .TASK_COUNT  (TASK_NUM),
        .MSG_WIDTH   (MSG_W)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .kind          (kind),
        .task_req      (task_req),
        .message       (message),
        .opt_flags     (opt_flags),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .status        (status),
        .message_out   (message_out),
        .woken_tasks   (woken_tasks),
        .message_count (message_count)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // task 0 owns the top bit of the waiter and woken masks
    function automatic logic [3:0] mask_of(input logic [1:0] t);
        return 4'b1000 >> t;
    endfunction

    // advance the shadow state by one request and return what the block owes
    function automatic queue_result_t apply_queue_op(input kind_t k, input logic [1:0] t,
                                                     input logic [MSG_W-1:0] m,
                                                     input logic [2:0] f);
        queue_result_t r;
        r.st    = STAT_OK;
        r.msg   = '0;
        r.woken = '0;
        case (k)
            KIND_PEND:
            begin
                // take the head, or park the caller on an empty ring
                if (held != 0)
                begin
                    r.msg    = ring_mem[head_ptr];
                    head_ptr = head_ptr + 4'd1;
                    held     = held - 5'd1;
                end
                else
                begin
                    wait_mask = wait_mask | mask_of(t);
                    r.st      = STAT_WAITING;
                end
            end
            KIND_POST:
            begin
                if (held == RING_DEPTH)
                    r.st = STAT_FULL;
                else if (wait_mask != 0)
                begin
                    // hand off past the ring, highest priority first, all on broadcast
                    for (int i = 0; i < TASK_NUM; i++)
                    begin
                        if ((wait_mask & mask_of(i[1:0])) != 0)
                        begin
                            r.woken     = r.woken | mask_of(i[1:0]);
                            wait_mask   = wait_mask & ~mask_of(i[1:0]);
                            slot_msg[i] = m;
                            if (!f[FLAG_BROADCAST])
                                break;
                        end
                    end
                end
                else if (m != 0)
                begin
                    // a null message with nobody waiting is dropped
                    if (f[FLAG_FRONT])
                    begin
                        head_ptr           = head_ptr - 4'd1;
                        ring_mem[head_ptr] = m;
                    end
                    else
                    begin
                        ring_mem[tail_ptr] = m;
                        tail_ptr           = tail_ptr + 4'd1;
                    end
                    held = held + 5'd1;
                end
            end
            KIND_ACCEPT:
            begin
                if (held == 0)
                    r.st = STAT_EMPTY;
                else
                begin
                    r.msg = ring_mem[head_ptr];
                    if (f[FLAG_REMOVE])
                    begin
                        head_ptr = head_ptr + 4'd1;
                        held     = held - 5'd1;
                    end
                end
            end
            default:
            begin
                // resume: an empty slot means the wait timed out
                if (slot_msg[t] != 0)
                begin
                    r.msg       = slot_msg[t];
                    slot_msg[t] = '0;
                end
                else
                begin
                    wait_mask = wait_mask & ~mask_of(t);
                    r.st      = STAT_TIMEOUT;
                end
            end
        endcase
        r.count = held;
        return r;
    endfunction

    // the receiver stalls at random, decided at each falling edge
    always @(negedge clk)
        rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);

    // result checker: every taken result is matched against the oldest one owed
    always @(posedge clk)
    begin
        queue_result_t want;
        queue_result_t got;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            got = {status_t'(status), message_out, woken_tasks, message_count};
            if (owed_results.size() == 0)
            begin
                $display("%0t unexpected result status %0d message %0h woken %h count %0d",
                         $time, status, message_out, woken_tasks, message_count);
                failures++;
            end
            else
            begin
                want = owed_results.pop_front();
                if (got !== want)
                begin
                    $display("%0t mismatch expected status %0d message %0h woken %h count %0d",
                             $time, want.st, want.msg, want.woken, want.count);
                    $display("%0t          actual   status %0d message %0h woken %h count %0d",
                             $time, status, message_out, woken_tasks, message_count);
                    failures++;
                end
            end
        end
    end

    // send one request; called at a falling edge, returns at the falling edge after
    // the accepting edge, with the old request still driven until the next one or a drain
    task automatic send_request(input kind_t k, input logic [1:0] t,
                                input logic [MSG_W-1:0] m, input logic [2:0] f);
        // random gaps on the request side
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        kind      <= k;
        task_req  <= t;
        message   <= m;
        opt_flags <= f;
        // hold the request until it is taken
        forever
        begin
            @(posedge clk);
            if (!req_stall)
                break;
        end
        owed_results.push_back(apply_queue_op(k, t, m, f));
        @(negedge clk);
    endtask

    // the sender holds off until every owed result has come back
    task automatic wait_drained();
        req_valid <= 1'b0;
        @(negedge clk);
        while (owed_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // waiters, single handoff to the top priority, broadcast to the rest
    task automatic test_pend_handoff();
        send_request(KIND_PEND,   2'd2, 8'h00, 3'b000);
        send_request(KIND_PEND,   2'd0, 8'h00, 3'b000);
        send_request(KIND_PEND,   2'd3, 8'h00, 3'b000);
        send_request(KIND_POST,   2'd1, 8'h5a, 3'b000);
        send_request(KIND_RESUME, 2'd0, 8'h00, 3'b000);
        send_request(KIND_POST,   2'd1, 8'hff, 3'b111);
        send_request(KIND_RESUME, 2'd2, 8'h00, 3'b000);
        send_request(KIND_RESUME, 2'd3, 8'h00, 3'b000);
    endtask

    // null messages, to a waiter and to nobody, and a resume with nothing handed off
    task automatic test_null_post();
        send_request(KIND_PEND,   2'd3, 8'h00, 3'b000);
        send_request(KIND_POST,   2'd0, 8'h00, 3'b000);
        send_request(KIND_RESUME, 2'd3, 8'h00, 3'b000);
        send_request(KIND_POST,   2'd2, 8'h00, 3'b010);
        send_request(KIND_RESUME, 2'd1, 8'hff, 3'b111);
    endtask

    // back and front posts, peek, removing accept, pend with data, empty accept
    task automatic test_ring_order();
        send_request(KIND_POST,   2'd0, 8'h01, 3'b000);
        send_request(KIND_POST,   2'd3, 8'h80, 3'b010);
        send_request(KIND_ACCEPT, 2'd1, 8'h00, 3'b000);
        send_request(KIND_ACCEPT, 2'd2, 8'h00, 3'b100);
        send_request(KIND_PEND,   2'd1, 8'h00, 3'b000);
        send_request(KIND_ACCEPT, 2'd0, 8'h00, 3'b111);
    endtask

    // random traffic in bursts of one shape, so the ring fills, drains and parks waiters
    task automatic test_random_traffic(input int n);
        traffic_mix_t     mix;
        kind_t            k;
        logic [MSG_W-1:0] m;
        int               pick;
        mix = MIX_ANY;
        for (int i = 0; i < n; i++)
        begin
            if (i % 40 == 0)
                mix = traffic_mix_t'($urandom_range(0, 3));
            pick = $urandom_range(0, 9);
            case (mix)
                MIX_FILL:
                    k = (pick < 9) ? KIND_POST : KIND_ACCEPT;
                MIX_DRAIN:
                    k = (pick < 5) ? KIND_PEND : ((pick < 9) ? KIND_ACCEPT : KIND_POST);
                MIX_WAITERS:
                    k = (pick < 4) ? KIND_PEND : ((pick < 7) ? KIND_POST : KIND_RESUME);
                default:
                    k = kind_t'($urandom_range(0, 3));
            endcase
            // mostly real messages, now and then a null one
            m = ($urandom_range(0, 11) == 0) ? '0 : MSG_W'($urandom_range(1, 255));
            send_request(k, 2'($urandom_range(0, 3)), m, 3'($urandom_range(0, 7)));
            // halfway through, the sender waits for everything to come back
            if (i == n / 2)
                wait_drained();
        end
    endtask

    // hard stop in case the block hangs
    initial
    begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        int settle;
        // known values on every input from time zero
        rst_n     = 1'b0;
        req_valid = 1'b0;
        rsp_stall = 1'b0;
        kind      = KIND_PEND;
        task_req  = '0;
        message   = '0;
        opt_flags = '0;
        failures  = 0;
        set_idling(0, 0);
        // shadow state starts where the block comes out of reset
        for (int i = 0; i < RING_DEPTH; i++)
            ring_mem[i] = '0;
        for (int i = 0; i < TASK_NUM; i++)
            slot_msg[i] = '0;
        head_ptr  = '0;
        tail_ptr  = '0;
        held      = '0;
        wait_mask = '0;

        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // light sender, heavy receiver stall
        set_idling(19, 75);
        test_pend_handoff();
        test_null_post();
        test_ring_order();
        test_random_traffic(500);
        wait_drained();

        // heavy sender gaps, light receiver stall
        set_idling(75, 19);
        test_random_traffic(500);
        wait_drained();

        // back to back in both directions
        set_idling(0, 0);
        test_random_traffic(500);

        // let the last results drain, then a short settle
        req_valid <= 1'b0;
        settle = 0;
        while (owed_results.size() != 0 && settle < 10000)
        begin
            @(negedge clk);
            settle++;
        end
        repeat (20) @(negedge clk);
        if (owed_results.size() != 0)
        begin
            $display("%0t %0d results never arrived", $time, owed_results.size());
            failures++;
        end

        if (failures == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

`default_nettype wire

### filelist.f
+incdir+sv
sv/rmq_pkg.sv
sv/rmq_ctrl.sv
sv/rmq_datapath.sv
sv/rtos_message_queue.sv
tb/tb.sv
